@@ rtl/bast_pkg.sv @@
// Shared types and constants for the advertisement signature tracker.
package bast_pkg;

  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int ADDR_W  = 48;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] ST_NO_MATCH  = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_UPDATED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [31:0] SIG_NEARBY  = 32'h1EFF4C00;
  localparam logic [31:0] SIG_OFFLINE = 32'h4C001219;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload_byte;
    logic               last_byte;
    logic [ADDR_W-1:0]  device_address;
    logic               address_type;
    logic signed [7:0]  signal_strength;
    logic [INDEX_W-1:0] entry_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [INDEX_W-1:0] entry_index;
    logic [COUNT_W-1:0] entry_count;
    logic [ADDR_W-1:0]  found_address;
    logic               found_address_type;
    logic signed [7:0]  found_signal_strength;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [ADDR_W-1:0]  addr;
    logic               addr_type;
    logic signed [7:0]  rssi;
    logic [INDEX_W-1:0] index;
  } tbl_cmd_t;

  typedef struct packed {
    logic      done;
    out_item_t item;
  } tbl_rsp_t;

endpackage

@@ rtl/bast_window.sv @@
// Four-byte sliding window signature detector over one report.
module bast_window (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] byte_val,
  input  logic       last,
  output logic       rpt_hit
);

  logic [23:0] recent_r, recent_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        hit_r, hit_nxt;
  logic        win_match;
  logic [31:0] win;

  assign win       = {recent_r, byte_val};
  assign win_match = (seen_r == 2'd3) &&
                     (win == bast_pkg::SIG_NEARBY || win == bast_pkg::SIG_OFFLINE);
  assign rpt_hit   = hit_r | win_match;

  always_comb begin
    recent_nxt = recent_r;
    seen_nxt   = seen_r;
    hit_nxt    = hit_r;
    if (byte_en) begin
      if (last) begin
        recent_nxt = '0;
        seen_nxt   = '0;
        hit_nxt    = 1'b0;
      end else begin
        recent_nxt = {recent_r[15:0], byte_val};
        seen_nxt   = (seen_r == 2'd3) ? seen_r : seen_r + 2'd1;
        hit_nxt    = rpt_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      seen_r   <= '0;
      hit_r    <= 1'b0;
    end else begin
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
      hit_r    <= hit_nxt;
    end
  end

endmodule

@@ rtl/bast_table.sv @@
// Device table memory with a sequencer that scans one entry per cycle.
module bast_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_go,
  input  bast_pkg::tbl_cmd_t             cmd,
  output logic                           busy,
  output logic [bast_pkg::COUNT_W-1:0]   entry_count,
  output bast_pkg::tbl_rsp_t             rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [bast_pkg::ADDR_W-1:0] mem_addr [TABLE_DEPTH];
  logic                        mem_type [TABLE_DEPTH];
  logic [7:0]                  mem_rssi [TABLE_DEPTH];

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic [bast_pkg::ADDR_W-1:0] key_addr_r, key_addr_nxt;
  logic                        key_type_r, key_type_nxt;
  logic signed [7:0]           key_rssi_r, key_rssi_nxt;

  logic [bast_pkg::ADDR_W-1:0] rd_addr_r;
  logic                        rd_type_r;
  logic [7:0]                  rd_rssi_r;

  logic             rd_en, wr_new, wr_upd;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic             hit;

  assign busy        = (state_r != S_IDLE);
  assign entry_count = bast_pkg::COUNT_W'(count_r);
  assign hit         = cmp_v_r && (rd_addr_r == key_addr_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    key_addr_nxt = key_addr_r;
    key_type_nxt = key_type_r;
    key_rssi_nxt = key_rssi_r;
    rd_en        = 1'b0;
    rd_idx       = ptr_r[IDX_W-1:0];
    wr_new       = 1'b0;
    wr_upd       = 1'b0;
    wr_idx       = cmp_idx_r;
    rsp          = '0;
    rsp.item.entry_count = bast_pkg::COUNT_W'(count_r);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_go) begin
          unique case (cmd.op)
            bast_pkg::OP_READ: begin
              if (bast_pkg::COUNT_W'(cmd.index) < bast_pkg::COUNT_W'(count_r)) begin
                rd_en       = 1'b1;
                rd_idx      = cmd.index[IDX_W-1:0];
                cmp_idx_nxt = cmd.index[IDX_W-1:0];
                state_nxt   = S_READ;
              end else begin
                rsp.done             = 1'b1;
                rsp.item.status      = bast_pkg::ST_BAD_INDEX;
                rsp.item.entry_index = cmd.index;
              end
            end
            bast_pkg::OP_CLEAR: begin
              count_nxt            = '0;
              rsp.done             = 1'b1;
              rsp.item.status      = bast_pkg::ST_CLEARED;
              rsp.item.entry_count = '0;
            end
            bast_pkg::OP_SEARCH: begin
              ptr_nxt      = '0;
              key_addr_nxt = cmd.addr;
              key_type_nxt = cmd.addr_type;
              key_rssi_nxt = cmd.rssi;
              state_nxt    = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        rsp.done                       = 1'b1;
        rsp.item.status                = bast_pkg::ST_READ;
        rsp.item.entry_index           = bast_pkg::INDEX_W'(cmp_idx_r);
        rsp.item.found_address         = rd_addr_r;
        rsp.item.found_address_type    = rd_type_r;
        rsp.item.found_signal_strength = rd_rssi_r;
        state_nxt                      = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          wr_upd                         = 1'b1;
          wr_idx                         = cmp_idx_r;
          rsp.done                       = 1'b1;
          rsp.item.status                = bast_pkg::ST_UPDATED;
          rsp.item.entry_index           = bast_pkg::INDEX_W'(cmp_idx_r);
          rsp.item.found_address         = rd_addr_r;
          rsp.item.found_address_type    = rd_type_r;
          rsp.item.found_signal_strength = key_rssi_r;
          state_nxt                      = S_IDLE;
        end else if (ptr_r < count_r) begin
          // issue read; compare lands next cycle
          rd_en       = 1'b1;
          rd_idx      = ptr_r[IDX_W-1:0];
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt     = ptr_r + CNT_W'(1);
        end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
          rsp.done        = 1'b1;
          rsp.item.status = bast_pkg::ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          wr_new                         = 1'b1;
          wr_idx                         = count_r[IDX_W-1:0];
          count_nxt                      = count_r + CNT_W'(1);
          rsp.done                       = 1'b1;
          rsp.item.status                = bast_pkg::ST_ADDED;
          rsp.item.entry_index           = bast_pkg::INDEX_W'(count_r);
          rsp.item.entry_count           = bast_pkg::COUNT_W'(count_nxt);
          rsp.item.found_address         = key_addr_r;
          rsp.item.found_address_type    = key_type_r;
          rsp.item.found_signal_strength = key_rssi_r;
          state_nxt                      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      mem_addr[wr_idx] <= key_addr_r;
      mem_type[wr_idx] <= key_type_r;
      mem_rssi[wr_idx] <= key_rssi_r;
    end
    if (wr_upd) begin
      mem_rssi[wr_idx] <= key_rssi_r;
    end
    if (rd_en) begin
      rd_addr_r <= mem_addr[rd_idx];
      rd_type_r <= mem_type[rd_idx];
      rd_rssi_r <= mem_rssi[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    key_addr_r <= key_addr_nxt;
    key_type_r <= key_type_nxt;
    key_rssi_r <= key_rssi_nxt;
  end

endmodule

@@ rtl/ble_advert_signature_tracker.sv @@
// Top level of the advertisement signature tracker.
//
// Usage: drive in_item and pulse start; a transaction is taken at a clock
// edge with start high and busy low. Kinds: payload byte, read entry,
// clear table. Payload bytes are dropped while scan_enable (cfg_we /
// cfg_wdata) is zero.
// Each result appears on out_item for one cycle with out_valid high.
// Timing: a non-final byte gives no result and busy stays low. A final
// byte of a non-matching report, a clear or an out-of-range read gives its
// result in the cycle after acceptance. An in-range read goes through the
// read state and then the output register. A matching report scans the
// table one entry per cycle through a single read port and comparator,
// stops at the first hit, and busy is high while the scan runs.
// Reset empties the table, clears the byte window and disables scanning.
// The receiver cannot stall; results are never held.
module ble_advert_signature_tracker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bast_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bast_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  logic                         scan_en_r;
  logic                         out_valid_r, out_valid_nxt;
  bast_pkg::out_item_t          out_item_r, out_item_nxt;
  logic                         accept, byte_en, rpt_hit, nomatch, tbl_go, tbl_busy;
  bast_pkg::tbl_cmd_t           cmd;
  bast_pkg::tbl_rsp_t           rsp;
  logic [bast_pkg::COUNT_W-1:0] count;

  assign accept  = start && !busy;
  assign byte_en = accept && (in_item.kind == bast_pkg::KIND_BYTE) && scan_en_r;
  assign nomatch = byte_en && in_item.last_byte && !rpt_hit;
  assign tbl_go  = (byte_en && in_item.last_byte && rpt_hit) ||
                   (accept && (in_item.kind == bast_pkg::KIND_READ ||
                               in_item.kind == bast_pkg::KIND_CLEAR));
  assign busy    = tbl_busy;

  always_comb begin
    cmd.addr      = in_item.device_address;
    cmd.addr_type = in_item.address_type;
    cmd.rssi      = in_item.signal_strength;
    cmd.index     = in_item.entry_number;
    unique case (in_item.kind)
      bast_pkg::KIND_READ:  cmd.op = bast_pkg::OP_READ;
      bast_pkg::KIND_CLEAR: cmd.op = bast_pkg::OP_CLEAR;
      default:              cmd.op = bast_pkg::OP_SEARCH;
    endcase
  end

  bast_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .byte_val (in_item.payload_byte),
    .last     (in_item.last_byte),
    .rpt_hit  (rpt_hit)
  );

  bast_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_go      (tbl_go),
    .cmd         (cmd),
    .busy        (tbl_busy),
    .entry_count (count),
    .rsp         (rsp)
  );

  always_comb begin
    out_valid_nxt = rsp.done || nomatch;
    out_item_nxt  = rsp.item;
    if (nomatch) begin
      out_item_nxt             = '0;
      out_item_nxt.status      = bast_pkg::ST_NO_MATCH;
      out_item_nxt.entry_count = count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        scan_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for ble_advert_signature_tracker: random reports, reads and clears.
module tb_top;

  localparam int DEPTH       = 16;
  localparam int SETTLE      = DEPTH + 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE   = 24;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class sighting_board;
    bit                          scan_on;
    logic [23:0]                 win_bytes;
    int unsigned                 win_fill;
    bit                          sig_seen;
    logic [bast_pkg::ADDR_W-1:0] dev_addr [DEPTH];
    logic                        dev_type [DEPTH];
    logic signed [7:0]           dev_rssi [DEPTH];
    int unsigned                 dev_count;
    bast_pkg::out_item_t         due_reports [$];
    int                          errors;

    function bast_pkg::out_item_t outcome(logic [2:0] st, int unsigned idx, bit has_entry);
      bast_pkg::out_item_t r;
      r = '0;
      r.status      = st;
      r.entry_index = idx[bast_pkg::INDEX_W-1:0];
      r.entry_count = dev_count[bast_pkg::COUNT_W-1:0];
      if (has_entry) begin
        r.found_address         = dev_addr[idx];
        r.found_address_type    = dev_type[idx];
        r.found_signal_strength = dev_rssi[idx];
      end
      return r;
    endfunction

    function void take_input(bast_pkg::in_item_t it);
      logic [31:0] win;
      bit          matched;
      case (it.kind)
        bast_pkg::KIND_BYTE: begin
          if (!scan_on) return;
          if (win_fill >= 3) begin
            win = {win_bytes, it.payload_byte};
            if (win == bast_pkg::SIG_NEARBY || win == bast_pkg::SIG_OFFLINE) sig_seen = 1'b1;
          end else begin
            win_fill++;
          end
          win_bytes = {win_bytes[15:0], it.payload_byte};
          if (!it.last_byte) return;
          matched   = sig_seen;
          win_bytes = '0;
          win_fill  = 0;
          sig_seen  = 1'b0;
          if (!matched) begin
            due_reports.push_back(outcome(bast_pkg::ST_NO_MATCH, 0, 1'b0));
            return;
          end
          for (int i = 0; i < dev_count; i++) begin
            if (dev_addr[i] == it.device_address) begin
              dev_rssi[i] = it.signal_strength;
              due_reports.push_back(outcome(bast_pkg::ST_UPDATED, i, 1'b1));
              return;
            end
          end
          if (dev_count >= DEPTH) begin
            due_reports.push_back(outcome(bast_pkg::ST_FULL, 0, 1'b0));
            return;
          end
          dev_addr[dev_count] = it.device_address;
          dev_type[dev_count] = it.address_type;
          dev_rssi[dev_count] = it.signal_strength;
          dev_count++;
          due_reports.push_back(outcome(bast_pkg::ST_ADDED, dev_count - 1, 1'b1));
        end
        bast_pkg::KIND_READ: begin
          if (it.entry_number < dev_count)
            due_reports.push_back(outcome(bast_pkg::ST_READ, 32'(it.entry_number), 1'b1));
          else
            due_reports.push_back(outcome(bast_pkg::ST_BAD_INDEX, 32'(it.entry_number),
                                          1'b0));
        end
        bast_pkg::KIND_CLEAR: begin
          dev_count = 0;
          due_reports.push_back(outcome(bast_pkg::ST_CLEARED, 0, 1'b0));
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task check_report(bast_pkg::out_item_t got);
      bast_pkg::out_item_t want;
      if (due_reports.size() == 0) begin
        report($sformatf("result with none pending, status %0d", got.status));
        return;
      end
      want = due_reports.pop_front();
      field("status", 64'(got.status), 64'(want.status));
      field("entry_index", 64'(got.entry_index), 64'(want.entry_index));
      field("entry_count", 64'(got.entry_count), 64'(want.entry_count));
      field("found_address", 64'(got.found_address), 64'(want.found_address));
      field("found_address_type", 64'(got.found_address_type),
            64'(want.found_address_type));
      field("found_signal_strength", 64'(got.found_signal_strength),
            64'(want.found_signal_strength));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  bast_pkg::in_item_t  in_item;
  logic                out_valid;
  bast_pkg::out_item_t out_item;
  logic                cfg_we;
  logic                cfg_wdata;

  sighting_board               sb;
  int                          quiet;
  int                          burst_left;
  int                          counted;
  logic [bast_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

  ble_advert_signature_tracker #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.scan_on = cfg_wdata;
      if (out_valid) sb.check_report(out_item);
      if (start && !busy) sb.take_input(in_item);
    end
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("** ble_advert_signature_tracker: FAILED **");
      $finish;
    end
  end

  function automatic bast_pkg::in_item_t rand_item();
    bast_pkg::in_item_t it;
    logic [63:0]        w;
    w = {$urandom, $urandom};
    it.kind            = 2'($urandom_range(0, 3));
    it.payload_byte    = 8'($urandom_range(0, 255));
    it.last_byte       = 1'($urandom_range(0, 1));
    it.device_address  = w[bast_pkg::ADDR_W-1:0];
    it.address_type    = 1'($urandom_range(0, 1));
    it.signal_strength = 8'($urandom_range(0, 255));
    it.entry_number    = 6'($urandom_range(0, 63));
    return it;
  endfunction

  task automatic send(bast_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue(bast_pkg::in_item_t it);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    counted++;
    send(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.due_reports.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_scan(bit on);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_cmd(logic [1:0] kind, logic [bast_pkg::INDEX_W-1:0] entry);
    bast_pkg::in_item_t it;
    it = rand_item();
    it.kind         = kind;
    it.entry_number = entry;
    issue(it);
  endtask

  // sends the low n bytes of seq, oldest first; the last one closes the report
  task automatic send_bytes(logic [63:0] seq, int n, logic [bast_pkg::ADDR_W-1:0] addr,
                            logic atype, logic signed [7:0] rssi);
    bast_pkg::in_item_t it;
    for (int k = 0; k < n; k++) begin
      it = rand_item();
      it.kind         = bast_pkg::KIND_BYTE;
      it.payload_byte = seq[8*(n-1-k) +: 8];
      it.last_byte    = (k == n - 1);
      if (k == n - 1) begin
        it.device_address  = addr;
        it.address_type    = atype;
        it.signal_strength = rssi;
      end
      issue(it);
    end
  endtask

  task automatic send_report();
    logic [63:0]                 seq;
    logic [31:0]                 sig;
    logic [bast_pkg::ADDR_W-1:0] addr;
    logic [63:0]                 w;
    int                          n;
    int                          mode;
    seq  = '0;
    n    = 0;
    mode = $urandom_range(0, 9);
    sig  = $urandom_range(0, 1) ? bast_pkg::SIG_NEARBY : bast_pkg::SIG_OFFLINE;
    if (mode < 8) begin
      repeat ($urandom_range(0, 2)) begin
        seq = {seq[55:0], 8'($urandom_range(0, 255))};
        n++;
      end
      seq = {seq[39:0], sig[31:8]};
      n += 3;
      // broken signature when mode is 6 or 7: last byte spoiled
      seq = {seq[55:0], (mode < 6) ? sig[7:0] : sig[7:0] ^ 8'($urandom_range(1, 255))};
      n++;
      repeat ($urandom_range(0, 2)) begin
        seq = {seq[55:0], 8'($urandom_range(0, 255))};
        n++;
      end
    end else begin
      n = $urandom_range(1, 8);
      seq = {$urandom, $urandom};
    end
    w = {$urandom, $urandom};
    addr = ($urandom_range(0, 4) == 0) ? w[bast_pkg::ADDR_W-1:0]
                                       : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_bytes(seq, n, addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic random_step();
    bast_pkg::in_item_t it;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_report();
    end else if (r < 88) begin
      if (sb.dev_count != 0 && $urandom_range(0, 9) < 7)
        send_cmd(bast_pkg::KIND_READ, 6'($urandom_range(0, sb.dev_count - 1)));
      else
        send_cmd(bast_pkg::KIND_READ, 6'($urandom_range(0, 63)));
    end else if (r < 90) begin
      send_cmd(bast_pkg::KIND_CLEAR, 6'($urandom_range(0, 63)));
    end else if (r < 95) begin
      it = rand_item();
      it.kind = bast_pkg::KIND_BYTE;
      issue(it);
    end else begin
      send_cmd(KIND_UNUSED, 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    int phase_len [5];
    bit drained;
    logic [63:0] w;
    sb = new;
    burst_left = 0;
    counted    = 0;
    drained    = 1'b0;
    phase_len  = '{200, 12, 150, 10, 110};
    for (int i = 0; i < POOL_SIZE; i++) begin
      w = {$urandom, $urandom};
      addr_pool[i] = w[bast_pkg::ADDR_W-1:0];
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scanning is off after reset: a valid signature is dropped
    send_bytes(64'h1EFF4C00, 4, '0, 1'b0, -8'sd128);
    set_scan(1'b1);
    send_cmd(bast_pkg::KIND_READ, 6'd0);
    send_bytes(64'h1EFF4C00, 4, '0, 1'b0, -8'sd128);
    // same address, other type: strength replaced, type kept
    send_bytes(64'h114C001219, 5, '0, 1'b1, 8'sd127);
    send_bytes(64'h1EFF4C, 3, '1, 1'b1, 8'sd5);
    send_bytes(64'h4C001219, 4, '1, 1'b1, 8'sd0);
    send_cmd(bast_pkg::KIND_READ, 6'd1);
    send_cmd(bast_pkg::KIND_READ, 6'd63);
    send_cmd(KIND_UNUSED, 6'd0);
    send_cmd(bast_pkg::KIND_CLEAR, 6'd0);
    send_bytes(64'h5A, 1, '1, 1'b0, -8'sd1);

    for (int p = 0; p < 5; p++) begin
      set_scan(p % 2 == 0);
      counted = 0;
      while (counted < phase_len[p]) begin
        random_step();
        if (p == 0 && !drained && counted >= 100) begin
          drain();
          drained = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** ble_advert_signature_tracker: PASSED **");
    end else begin
      $display("** ble_advert_signature_tracker: FAILED **");
    end
    $finish;
  end

endmodule
